>>> rtl/brmq_pkg.sv
// shared types and constants for the block range minimum engine
package brmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int MAX_BLOCKS   = 1024;
    // element and block indexes share one width since both stores are equally deep
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int DIV_STEPS    = IDX_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    localparam logic [CFG_W-1:0] ELEMENT_COUNT_RST = 11'd1024;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST    = 11'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_SCAN_HEAD,
        ST_SCAN_BLK,
        ST_SCAN_TAIL,
        ST_DRAIN,
        ST_RESULT
    } state_t;

endpackage

>>> rtl/brmq_ram.sv
// generic simple dual port ram with registered read
module brmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/block_range_min_query_top.sv
// range minimum engine over an element store and a per-block minimum store
//
// input channel (s_*): one item per handshake. a load item (req_type 0) writes
// load_value at load_index and folds it into its block minimum; a load at the
// first index of a block starts that block afresh. a query item (req_type 1)
// returns one result item on the m_* channel with the minimum over
// [range_left, range_right], or range_error with 0x7fffffff when the range is
// empty or reaches element_count.
// configuration: cfg_wr_en writes cfg_wr_data into element_count (index 0) or
// block_size (index 1, zero acts as one); write only while the engine is idle.
// one item is worked at a time. a load runs the bit-per-cycle divider that
// finds the block, then a read and a write of the block minimum store. a
// query runs two divisions, then the memory reads: the partial edge blocks
// element by element plus the whole blocks between (up to about
// 2*block_size + count/block_size reads, one read per cycle). a rejected
// query goes straight to its result.
// the result sits in an output register; a new item is taken while it waits,
// and a query only holds in its last state while m_ready stays low.
// reset (synchronous, active low) empties the engine and restores
// element_count 1024 and block_size 32; the stores keep their contents.
module block_range_min_query_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [brmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brmq_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [brmq_pkg::IDX_W-1:0]         s_load_index,
    input  logic signed [brmq_pkg::DATA_W-1:0] s_load_value,
    input  logic [brmq_pkg::IDX_W-1:0]         s_range_left,
    input  logic [brmq_pkg::IDX_W-1:0]         s_range_right,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [brmq_pkg::DATA_W-1:0] m_range_minimum,
    output logic                               m_range_error
);

    localparam int IDX_W  = brmq_pkg::IDX_W;
    localparam int DATA_W = brmq_pkg::DATA_W;
    localparam int CFG_W  = brmq_pkg::CFG_W;
    localparam int CNT_W  = brmq_pkg::DIV_CNT_W;

    brmq_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0]  element_count_reg, block_size_reg;
    logic [CFG_W-1:0]  bs_eff;

    // item registers
    logic              is_load_reg;
    logic [DATA_W-1:0] val_reg;
    logic [IDX_W-1:0]  left_reg, right_reg;
    logic              err_reg;

    // divider
    logic [IDX_W-1:0]  div_dvd_reg, div_rem_reg, div_quo_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [IDX_W:0]    div_trial;
    logic [IDX_W:0]    div_sub;
    logic              div_ge, div_last;
    logic [IDX_W-1:0]  rem_step, quo_step;

    logic [IDX_W-1:0]  lb_reg, rema_reg, rb_reg, remb_reg;
    logic [CFG_W:0]    head_end;
    logic [IDX_W-1:0]  tail_start;
    logic              blocks_between;

    // scan
    logic [IDX_W-1:0]  scan_idx_reg, scan_end_reg;
    logic              scan_last, scan_state;
    logic              rd_pend_reg, rd_blk_reg;
    logic [DATA_W-1:0] min_reg, cmp_data;

    // memories
    logic              elem_we, bm_we;
    logic [IDX_W-1:0]  bm_raddr;
    logic [DATA_W-1:0] elem_rdata, bm_rdata;

    // output register
    logic              m_valid_reg, out_free;
    logic [DATA_W-1:0] min_out_reg;
    logic              err_out_reg;

    logic              accept, query_bad;

    assign bs_eff = (block_size_reg == '0) ? CFG_W'(1) : block_size_reg;

    assign div_trial = {div_rem_reg, div_dvd_reg[IDX_W-1]};
    assign div_ge    = div_trial >= bs_eff;
    assign div_sub   = div_trial - bs_eff;
    assign rem_step  = div_ge ? div_sub[IDX_W-1:0] : div_trial[IDX_W-1:0];
    assign quo_step  = {div_quo_reg[IDX_W-2:0], div_ge};
    assign div_last  = div_cnt_reg == CNT_W'(brmq_pkg::DIV_STEPS - 1);

    // last element of the left block: left - left%bs + bs - 1
    assign head_end = (CFG_W+1)'(left_reg) - (CFG_W+1)'(rema_reg)
                    + (CFG_W+1)'(bs_eff) - (CFG_W+1)'(1);
    assign tail_start     = right_reg - remb_reg;
    assign blocks_between = ((IDX_W+1)'(lb_reg) + (IDX_W+1)'(1)) < (IDX_W+1)'(rb_reg);

    assign scan_last  = scan_idx_reg == scan_end_reg;
    assign scan_state = (state_reg == brmq_pkg::ST_SCAN_HEAD) ||
                        (state_reg == brmq_pkg::ST_SCAN_BLK)  ||
                        (state_reg == brmq_pkg::ST_SCAN_TAIL);
    assign cmp_data   = rd_blk_reg ? bm_rdata : elem_rdata;

    assign query_bad = (s_range_left > s_range_right) ||
                       ((CFG_W)'(s_range_right) >= element_count_reg);

    assign out_free = !m_valid_reg || m_ready;

    // control outputs
    always_comb begin
        s_ready  = state_reg == brmq_pkg::ST_IDLE;
        accept   = s_valid && s_ready;
        elem_we  = accept && (s_req_type == brmq_pkg::REQ_LOAD);
        bm_raddr = (state_reg == brmq_pkg::ST_LOAD_RD) ? lb_reg : scan_idx_reg;
        bm_we    = (state_reg == brmq_pkg::ST_LOAD_WR) &&
                   ((rema_reg == '0) || ($signed(val_reg) < $signed(bm_rdata)));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brmq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == brmq_pkg::REQ_QUERY && query_bad) begin
                        state_next = brmq_pkg::ST_RESULT;
                    end else begin
                        state_next = brmq_pkg::ST_DIV_A;
                    end
                end
            end
            brmq_pkg::ST_DIV_A: begin
                if (div_last) begin
                    state_next = is_load_reg ? brmq_pkg::ST_LOAD_RD : brmq_pkg::ST_DIV_B;
                end
            end
            brmq_pkg::ST_DIV_B: begin
                if (div_last) begin
                    state_next = brmq_pkg::ST_SCAN_HEAD;
                end
            end
            brmq_pkg::ST_LOAD_RD: state_next = brmq_pkg::ST_LOAD_WR;
            brmq_pkg::ST_LOAD_WR: state_next = brmq_pkg::ST_IDLE;
            brmq_pkg::ST_SCAN_HEAD: begin
                if (scan_last) begin
                    if (lb_reg == rb_reg) begin
                        state_next = brmq_pkg::ST_DRAIN;
                    end else if (blocks_between) begin
                        state_next = brmq_pkg::ST_SCAN_BLK;
                    end else begin
                        state_next = brmq_pkg::ST_SCAN_TAIL;
                    end
                end
            end
            brmq_pkg::ST_SCAN_BLK: begin
                if (scan_last) begin
                    state_next = brmq_pkg::ST_SCAN_TAIL;
                end
            end
            brmq_pkg::ST_SCAN_TAIL: begin
                if (scan_last) begin
                    state_next = brmq_pkg::ST_DRAIN;
                end
            end
            brmq_pkg::ST_DRAIN: state_next = brmq_pkg::ST_RESULT;
            brmq_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = brmq_pkg::ST_IDLE;
                end
            end
            default: state_next = brmq_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= brmq_pkg::ST_IDLE;
            element_count_reg <= brmq_pkg::ELEMENT_COUNT_RST;
            block_size_reg    <= brmq_pkg::BLOCK_SIZE_RST;
            rd_pend_reg       <= 1'b0;
            rd_blk_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= scan_state;
            rd_blk_reg  <= state_reg == brmq_pkg::ST_SCAN_BLK;
            if (cfg_wr_en) begin
                case (cfg_index)
                    brmq_pkg::CFG_ELEMENT_COUNT: element_count_reg <= cfg_wr_data;
                    brmq_pkg::CFG_BLOCK_SIZE:    block_size_reg    <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == brmq_pkg::ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            is_load_reg <= s_req_type == brmq_pkg::REQ_LOAD;
            val_reg     <= s_load_value;
            left_reg    <= s_range_left;
            right_reg   <= s_range_right;
            err_reg     <= (s_req_type == brmq_pkg::REQ_QUERY) && query_bad;
            div_dvd_reg <= (s_req_type == brmq_pkg::REQ_LOAD) ? s_load_index : s_range_left;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            div_cnt_reg <= '0;
            min_reg     <= brmq_pkg::INT_MAX;
        end

        if (state_reg == brmq_pkg::ST_DIV_A || state_reg == brmq_pkg::ST_DIV_B) begin
            div_quo_reg <= quo_step;
            if (div_last) begin
                div_cnt_reg <= '0;
                if (state_reg == brmq_pkg::ST_DIV_A) begin
                    lb_reg      <= quo_step;
                    rema_reg    <= rem_step;
                    // second division, right index
                    div_dvd_reg <= right_reg;
                    div_rem_reg <= '0;
                end else begin
                    rb_reg       <= quo_step;
                    remb_reg     <= rem_step;
                    scan_idx_reg <= left_reg;
                    scan_end_reg <= (lb_reg == quo_step) ? right_reg : head_end[IDX_W-1:0];
                end
            end else begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                div_dvd_reg <= {div_dvd_reg[IDX_W-2:0], 1'b0};
                div_rem_reg <= rem_step;
            end
        end

        if (scan_state) begin
            if (!scan_last) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end else if (state_reg == brmq_pkg::ST_SCAN_HEAD && blocks_between) begin
                scan_idx_reg <= lb_reg + IDX_W'(1);
                scan_end_reg <= rb_reg - IDX_W'(1);
            end else begin
                scan_idx_reg <= tail_start;
                scan_end_reg <= right_reg;
            end
        end

        // compare stage in the cycle after the read
        if (rd_pend_reg && ($signed(cmp_data) < $signed(min_reg))) begin
            min_reg <= cmp_data;
        end

        if (state_reg == brmq_pkg::ST_RESULT && out_free) begin
            min_out_reg <= err_reg ? brmq_pkg::INT_MAX : min_reg;
            err_out_reg <= err_reg;
        end
    end

    brmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (brmq_pkg::MAX_ELEMENTS)
    ) u_element_store (
        .aclk  (aclk),
        .we    (elem_we),
        .waddr (s_load_index),
        .wdata (s_load_value),
        .raddr (scan_idx_reg),
        .rdata (elem_rdata)
    );

    brmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (brmq_pkg::MAX_BLOCKS)
    ) u_block_minimum (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (lb_reg),
        .wdata (val_reg),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_range_minimum = min_out_reg;
    assign m_range_error   = err_out_reg;

`ifndef NO_ASSERTIONS
    a_err_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_error) |-> (m_range_minimum == brmq_pkg::INT_MAX))
        else $error("error result without max minimum");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_state |-> (scan_idx_reg <= scan_end_reg))
        else $error("scan index beyond scan end");

    a_rd_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> ($past(state_reg) == brmq_pkg::ST_SCAN_HEAD ||
                         $past(state_reg) == brmq_pkg::ST_SCAN_BLK ||
                         $past(state_reg) == brmq_pkg::ST_SCAN_TAIL))
        else $error("compare without a scan read");

    a_bm_write_load: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_we |-> (is_load_reg && $past(state_reg) == brmq_pkg::ST_LOAD_RD))
        else $error("block minimum written outside a load");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == brmq_pkg::ST_DIV_A || state_reg == brmq_pkg::ST_DIV_B) |->
        (div_cnt_reg <= CNT_W'(brmq_pkg::DIV_STEPS - 1)))
        else $error("divider step count overrun");
`endif

endmodule

>>> test/brmq_result_check.sv
// result checker for the block range minimum engine: predicts query results and compares them
`timescale 1ns / 1ps
module brmq_result_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [brmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brmq_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [brmq_pkg::IDX_W-1:0]         s_load_index,
    input  logic signed [brmq_pkg::DATA_W-1:0] s_load_value,
    input  logic [brmq_pkg::IDX_W-1:0]         s_range_left,
    input  logic [brmq_pkg::IDX_W-1:0]         s_range_right,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [brmq_pkg::DATA_W-1:0] m_range_minimum,
    input  logic                               m_range_error,
    output int                                 mismatch_count,
    output int                                 results_due
);
    import brmq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] minimum;
        logic                     error;
    } range_result_t;

    logic signed [DATA_W-1:0] element_copy   [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] block_min_copy [MAX_BLOCKS];
    logic [CFG_W-1:0]         count_reg;
    logic [CFG_W-1:0]         span_reg;
    range_result_t            minima_due [$];

    initial begin
        foreach (element_copy[i]) element_copy[i] = '0;
        foreach (block_min_copy[i]) block_min_copy[i] = '0;
        count_reg = ELEMENT_COUNT_RST;
        span_reg  = BLOCK_SIZE_RST;
    end

    function automatic int effective_span();
        return (span_reg == '0) ? 1 : int'(span_reg);
    endfunction

    function automatic void store_element(input int idx, input logic signed [DATA_W-1:0] val);
        int span;
        int blk;
        span = effective_span();
        if (idx >= MAX_ELEMENTS) return;
        element_copy[idx] = val;
        blk = idx / span;
        if (blk >= MAX_BLOCKS) return;
        // a load at a block start restarts that block's minimum
        if (idx % span == 0 || val < block_min_copy[blk]) block_min_copy[blk] = val;
    endfunction

    function automatic range_result_t scan_range_minimum(input int left, input int right);
        range_result_t            res;
        int                       span;
        int                       lb;
        int                       rb;
        int                       i;
        logic signed [DATA_W-1:0] m;
        span        = effective_span();
        m           = INT_MAX;
        res.minimum = INT_MAX;
        res.error   = 1'b1;
        if (left > right || right >= int'(count_reg) || right >= MAX_ELEMENTS) return res;
        lb = left / span;
        rb = right / span;
        if (rb >= MAX_BLOCKS) return res;
        if (lb == rb) begin
            for (i = left; i <= right; i++) if (element_copy[i] < m) m = element_copy[i];
        end else begin
            // partial head block, whole blocks through their minima, partial tail block
            for (i = left; i < (lb + 1) * span; i++) if (element_copy[i] < m) m = element_copy[i];
            for (i = lb + 1; i < rb; i++) if (block_min_copy[i] < m) m = block_min_copy[i];
            for (i = rb * span; i <= right; i++) if (element_copy[i] < m) m = element_copy[i];
        end
        res.minimum = m;
        res.error   = 1'b0;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        range_result_t want;
        if (!aresetn) begin
            count_reg = ELEMENT_COUNT_RST;
            span_reg  = BLOCK_SIZE_RST;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ELEMENT_COUNT) count_reg = cfg_wr_data;
                else if (cfg_index == CFG_BLOCK_SIZE) span_reg = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (minima_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result item with none expected, got minimum %0d error %0b",
                             $time, m_range_minimum, m_range_error);
                end else begin
                    want = minima_due.pop_front();
                    if (m_range_minimum !== want.minimum) begin
                        mismatch_count++;
                        $display("%0t: range_minimum expected %0d got %0d",
                                 $time, want.minimum, m_range_minimum);
                    end
                    if (m_range_error !== want.error) begin
                        mismatch_count++;
                        $display("%0t: range_error expected %0b got %0b",
                                 $time, want.error, m_range_error);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_LOAD)
                    store_element(int'(s_load_index), s_load_value);
                else
                    minima_due.push_back(scan_range_minimum(int'(s_range_left),
                                                            int'(s_range_right)));
            end
        end
        results_due = minima_due.size();
    end

endmodule

>>> test/block_range_min_query_top_tb.sv
// testbench top for the block range minimum engine: stimulus, flow control and verdict
`timescale 1ns / 1ps
module block_range_min_query_top_tb;
    import brmq_pkg::*;

    localparam int LONG_HOLD = 400;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index       = CFG_ELEMENT_COUNT;
    logic [CFG_W-1:0]         cfg_wr_data     = '0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic                     s_req_type      = REQ_LOAD;
    logic [IDX_W-1:0]         s_load_index    = '0;
    logic signed [DATA_W-1:0] s_load_value    = '0;
    logic [IDX_W-1:0]         s_range_left    = '0;
    logic [IDX_W-1:0]         s_range_right   = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic signed [DATA_W-1:0] m_range_minimum;
    logic                     m_range_error;

    int               mismatch_count;
    int               results_due;
    int               idle_mode   = 0;
    int               items_sent  = 0;
    bit               stall_flip  = 1'b0;
    logic [CFG_W-1:0] cur_count   = ELEMENT_COUNT_RST;
    int               cur_span    = 32;
    // leading elements written by load_all, random in-range queries stay below this
    int               filled      = 0;
    // block minima that hold a defined value, so mid-block loads never fold into garbage
    bit               block_min_set [MAX_BLOCKS];

    block_range_min_query_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_load_index    (s_load_index),
        .s_load_value    (s_load_value),
        .s_range_left    (s_range_left),
        .s_range_right   (s_range_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_range_minimum (m_range_minimum),
        .m_range_error   (m_range_error)
    );

    brmq_result_check result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_load_index    (s_load_index),
        .s_load_value    (s_load_value),
        .s_range_left    (s_range_left),
        .s_range_right   (s_range_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_range_minimum (m_range_minimum),
        .m_range_error   (m_range_error),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("[block_range_min_query_top] ERROR");
        $finish;
    end

    // result side: random stalls by mode, plus one long hold-off on request
    initial begin : receiver
        int hold;
        bit seen_flip;
        int pct;
        hold      = 0;
        seen_flip = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_flip != seen_flip) begin
                seen_flip = stall_flip;
                hold      = LONG_HOLD;
            end
            pct = (idle_mode == 2) ? 70 : (idle_mode == 3) ? 24 : 0;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= pct);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return INT_MAX;
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic kind, input int idx, input logic signed [DATA_W-1:0] val,
                             input int left, input int right);
        int mode;
        int pct;
        mode = (items_sent / 45) % 4;
        items_sent++;
        idle_mode <= mode;
        pct = (mode == 1) ? 70 : (mode == 3) ? 24 : 0;
        if ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_load_index  <= (kind == REQ_LOAD) ? IDX_W'(idx) : IDX_W'($urandom);
        s_load_value  <= (kind == REQ_LOAD) ? val : DATA_W'($urandom);
        s_range_left  <= (kind == REQ_QUERY) ? IDX_W'(left) : IDX_W'($urandom);
        s_range_right <= (kind == REQ_QUERY) ? IDX_W'(right) : IDX_W'($urandom);
        if (kind == REQ_LOAD && idx % cur_span == 0) block_min_set[idx / cur_span] = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        // a trailing load may still be working
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] span);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_ELEMENT_COUNT;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_index   <= CFG_BLOCK_SIZE;
        cfg_wr_data <= span;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_count = count;
        cur_span  = (span == '0) ? 1 : int'(span);
    endtask

    task automatic load_all(input int n);
        int i;
        for (i = 0; i < n; i++) push_item(REQ_LOAD, i, pick_value(), 0, 0);
        if (n > filled) filled = n;
    endtask

    task automatic random_items(input int n);
        int k;
        int pick;
        int lim;
        int top;
        int left;
        int right;
        int base;
        int i;
        lim = (cur_count > 11'd1024) ? MAX_ELEMENTS : int'(cur_count);
        top = (lim < filled) ? lim : filled;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 10 && cur_span <= 48) begin
                // refill one block from its first index up
                base = $urandom_range((MAX_ELEMENTS - 1) / cur_span) * cur_span;
                for (i = base; i < base + cur_span && i < MAX_ELEMENTS; i++)
                    push_item(REQ_LOAD, i, pick_value(), 0, 0);
            end else if (pick < 30) begin
                i = $urandom_range(MAX_ELEMENTS - 1);
                if (i % cur_span != 0 && !block_min_set[i / cur_span]) i -= i % cur_span;
                push_item(REQ_LOAD, i, pick_value(), 0, 0);
            end else if (pick < 80 && top > 0) begin
                right = $urandom_range(top - 1);
                if ($urandom_range(1))
                    left = right - $urandom_range((right < 2 * cur_span) ? right : 2 * cur_span);
                else
                    left = $urandom_range(right);
                push_item(REQ_QUERY, 0, 0, left, right);
            end else if (lim < MAX_ELEMENTS && $urandom_range(1)) begin
                right = $urandom_range(MAX_ELEMENTS - 1, lim);
                push_item(REQ_QUERY, 0, 0, $urandom_range(MAX_ELEMENTS - 1), right);
            end else begin
                right = $urandom_range(MAX_ELEMENTS - 2);
                push_item(REQ_QUERY, 0, 0, $urandom_range(MAX_ELEMENTS - 1, right + 1), right);
            end
        end
    endtask

    initial begin : stimulus
        logic signed [DATA_W-1:0] opening [12];
        int i;
        opening = '{INT_MAX, 7, -1, 0, {1'b1, 31'b0}, 100, 42, -5, 9, 3, -2, 8};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small store, blocks of three
        set_config(11'd12, 11'd3);
        for (i = 0; i < 12; i++) push_item(REQ_LOAD, i, opening[i], 0, 0);
        push_item(REQ_QUERY, 0, 0, 0, 0);
        push_item(REQ_QUERY, 0, 0, 0, 11);
        push_item(REQ_QUERY, 0, 0, 1, 2);
        push_item(REQ_QUERY, 0, 0, 2, 10);
        push_item(REQ_QUERY, 0, 0, 5, 5);
        // reversed ranges and ranges past the count
        push_item(REQ_QUERY, 0, 0, 7, 4);
        push_item(REQ_QUERY, 0, 0, 3, 12);
        push_item(REQ_QUERY, 0, 0, 1022, 1023);
        push_item(REQ_QUERY, 0, 0, 1023, 0);
        // mid-block load lowers a minimum, block-start load overwrites one
        push_item(REQ_LOAD, 7, -50, 0, 0);
        push_item(REQ_LOAD, 3, 77, 0, 0);
        push_item(REQ_QUERY, 0, 0, 0, 11);
        settle();

        // half the store; the long hold-off backs the engine up into its input
        set_config(11'd512, 11'd22);
        load_all(512);
        stall_flip <= ~stall_flip;
        random_items(50);
        settle();

        set_config(11'd64, 11'd8);
        random_items(30);
        settle();
        random_items(30);
        settle();

        // zero block size acts as one
        set_config(11'd1, 11'd0);
        load_all(1);
        random_items(20);
        settle();

        // count above the store, one block covering everything
        set_config(11'd2047, 11'd2047);
        random_items(30);
        settle();

        // empty count rejects every query
        set_config(11'd0, 11'd1);
        random_items(20);
        settle();

        set_config(11'd36, 11'd6);
        load_all(36);
        random_items(50);

        s_valid <= 1'b0;
        wait (results_due == 0);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[block_range_min_query_top] OK");
        else
            $display("[block_range_min_query_top] ERROR");
        $finish;
    end

endmodule
